>>> design/bmwf_pkg.sv
// Package for the binary majority window filter.
// Holds the channel payload types, fixed field widths and the row counter helper.
// No dependencies.
package bmwf_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned COL_OUT_W = 10;
  localparam int unsigned ROW_W     = 12;

  // Reset value of the image width register.
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

  // The row counter saturates at this value.
  localparam logic [ROW_W-1:0] ROW_TOP = 12'hFFF;

  // One input transaction: a pixel label and a frame start mark.
  typedef struct packed {
    logic label_bit;
    logic frame_start;
  } in_t;

  // One output transaction: majority decision and center coordinates.
  typedef struct packed {
    logic                 filtered_bit;
    logic [COL_OUT_W-1:0] center_column;
    logic [ROW_W-1:0]     center_row;
  } out_t;

  // Next row number, held at the top value once it is reached.
  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] row);
    logic [ROW_W-1:0] res;
    if (row == ROW_TOP) begin
      res = row;
    end else begin
      res = row + ROW_W'(1);
    end
    return res;
  endfunction

endpackage

>>> design/binary_majority_window_filter_core.sv
// Top level of the binary majority window filter.
// Instantiates bmwf_front, bmwf_fifo and bmwf_back; uses bmwf_pkg.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_data_i) takes one pixel label per
//   transaction in raster order; frame_start marks the first pixel of a frame.
//   Output channel (out_valid_o, out_stall_i, out_data_o) gives one transaction
//   per interior pixel: the majority vote over the WINDOW_SIZE x WINDOW_SIZE
//   window and the center column and row. Border pixels give none.
//   cfg_we_i / cfg_wdata_i write the image width; write it between frames.
// Timing:
//   One pixel per cycle sustained unless the output is held. A result passes
//   line store read, queue and output register after the pixel that completes
//   its window is accepted. The line store read port sets the rate.
// Reset:
//   Clears counters, window and queue; the width returns to 640. The line
//   store is not cleared; its stale contents are shifted out before any result.
// Stall:
//   A held output keeps its transaction; the two-entry queue absorbs the
//   pipeline, then in_stall_o rises until the output drains.
module binary_majority_window_filter_core #(
  parameter int unsigned WINDOW_SIZE = 5,
  parameter int unsigned MAX_WIDTH   = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bmwf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bmwf_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bmwf_pkg::out_t             out_data_o
);

  localparam int unsigned CNT_W   = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned ENTRY_W = 1 + CNT_W + bmwf_pkg::COL_OUT_W + bmwf_pkg::ROW_W;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               full;
  logic               q_valid;
  logic               pop;
  logic [ENTRY_W-1:0] q_data;

  // Front: handshake, positions and line store.
  bmwf_front #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Queue between front and back.
  bmwf_fifo #(
    .DATA_W (ENTRY_W)
  ) u_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_data_i   (push_data),
    .full_o        (full),
    .pop_i_ready_o (q_valid),
    .pop_i         (pop),
    .pop_data_o    (q_data)
  );

  // Back: window count and vote.
  bmwf_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/bmwf_fifo.sv
// Two-entry register queue between the front and the back of the filter.
// Generic data width; depends on nothing else.
module bmwf_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  output logic              pop_i_ready_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0] slot_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign full_o        = (count_q == 2'd2);
  assign pop_i_ready_o = (count_q != 2'd0);
  assign pop_data_o    = slot_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue fill count out of range");
`endif

endmodule

>>> design/bmwf_front.sv
// Front of the majority filter: pixel handshake, position counters, line store.
// Produces one queue entry per pixel with its column popcount. Uses bmwf_pkg.
module bmwf_front #(
  parameter int unsigned WINDOW_SIZE = 5,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned CNT_W       = $clog2(WINDOW_SIZE + 1),
  parameter int unsigned ENTRY_W     = 1 + CNT_W + bmwf_pkg::COL_OUT_W + bmwf_pkg::ROW_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bmwf_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bmwf_pkg::in_t              in_data_i,
  output logic                       push_o,
  output logic [ENTRY_W-1:0]         push_data_o,
  input  logic                       full_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CW    =
    ((COL_W > bmwf_pkg::CFG_W) ? COL_W : bmwf_pkg::CFG_W) + 1;
  localparam int unsigned HIST  = WINDOW_SIZE - 1;
  localparam int unsigned HALF  = WINDOW_SIZE / 2;
  localparam int unsigned ROW_W = bmwf_pkg::ROW_W;

  logic [bmwf_pkg::CFG_W-1:0] width_q;
  logic [COL_W-1:0]           col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;

  logic                               s1_valid_q;
  logic                               s1_bit_q;
  logic [COL_W-1:0]                   s1_col_q;
  logic                               s1_emit_q;
  logic [bmwf_pkg::COL_OUT_W-1:0]     s1_ccol_q;
  logic [ROW_W-1:0]                   s1_crow_q;
  logic                               fwd_q;
  logic [HIST-1:0]                    fwd_val_q;
  logic [HIST-1:0]                    rd_q;
  logic [HIST-1:0]                    line_mem [MAX_WIDTH];

  logic                           accept;
  logic                           s1_fire;
  logic [CW-1:0]                  width_ext;
  logic [CW-1:0]                  weff;
  logic [COL_W-1:0]               base_col;
  logic [ROW_W-1:0]               base_row;
  logic [COL_W-1:0]               cur_col;
  logic [ROW_W-1:0]               cur_row;
  logic [CW-1:0]                  cur_col_ext;
  logic [CW-1:0]                  ccol_full;
  logic                           cur_emit;
  logic [HIST-1:0]                hist;
  logic [WINDOW_SIZE-1:0]         colv;
  logic [HIST-1:0]                wr_val;
  logic [CNT_W-1:0]               col_cnt;

  // Handshake: the pixel stage holds while the queue is full.
  assign s1_fire    = s1_valid_q && !full_i;
  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Effective image width, clamped to one and to the line store size.
  assign width_ext = CW'(width_q);
  always_comb begin
    if (width_q == '0) begin
      weff = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      weff = CW'(MAX_WIDTH);
    end else begin
      weff = width_ext;
    end
  end

  // Position of the incoming pixel, with frame start and row wrap applied.
  always_comb begin
    base_col = in_data_i.frame_start ? '0 : col_q;
    base_row = in_data_i.frame_start ? '0 : row_q;
    if (CW'(base_col) >= weff) begin
      cur_col = '0;
      cur_row = bmwf_pkg::row_inc(base_row);
    end else begin
      cur_col = base_col;
      cur_row = base_row;
    end
    cur_col_ext = CW'(cur_col);
    cur_emit    = (cur_row >= ROW_W'(HIST)) && (cur_col_ext >= CW'(HIST));
    ccol_full   = cur_col_ext - CW'(HALF);
    if (cur_col_ext + CW'(1) >= weff) begin
      col_d = '0;
      row_d = bmwf_pkg::row_inc(cur_row);
    end else begin
      col_d = cur_col + COL_W'(1);
      row_d = cur_row;
    end
  end

  // Configuration register and position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= bmwf_pkg::WIDTH_RESET;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && (s1_col_q == cur_col);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Pixel stage payload; the forward value covers a write to the same column.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bit_q  <= in_data_i.label_bit;
      s1_col_q  <= cur_col;
      s1_emit_q <= cur_emit;
      s1_ccol_q <= ccol_full[bmwf_pkg::COL_OUT_W-1:0];
      s1_crow_q <= cur_row - ROW_W'(HALF);
      fwd_val_q <= wr_val;
    end
  end

  // Line store: one column of history rows per entry, read on accept.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_col_q] <= wr_val;
    end
    if (accept) begin
      rd_q <= line_mem[cur_col];
    end
  end

  // Vertical column of the window and its updated history.
  assign hist   = fwd_q ? fwd_val_q : rd_q;
  assign colv   = {hist, s1_bit_q};
  assign wr_val = colv[HIST-1:0];

  // Set bits in the vertical column.
  always_comb begin
    col_cnt = '0;
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      col_cnt = col_cnt + CNT_W'(colv[k]);
    end
  end

  assign push_o      = s1_fire;
  assign push_data_o = {s1_emit_q, col_cnt, s1_ccol_q, s1_crow_q};

`ifndef SYNTHESIS
  a_frame_start_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.frame_start |=> s1_col_q == '0)
    else $error("frame start did not restart at column zero");
  a_emit_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q |-> CW'(s1_col_q) >= CW'(HIST))
    else $error("result flagged for a border column");
`endif

endmodule

>>> design/bmwf_back.sv
// Back of the majority filter: sliding window of column counts and the vote.
// Drains the queue and drives the output register. Uses bmwf_pkg.
module bmwf_back #(
  parameter int unsigned WINDOW_SIZE = 5,
  parameter int unsigned CNT_W       = $clog2(WINDOW_SIZE + 1),
  parameter int unsigned ENTRY_W     = 1 + CNT_W + bmwf_pkg::COL_OUT_W + bmwf_pkg::ROW_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  logic [ENTRY_W-1:0]  q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmwf_pkg::out_t      out_data_o
);

  localparam int unsigned SUM_W  = $clog2(WINDOW_SIZE * WINDOW_SIZE + 1);
  localparam int unsigned THRESH = (WINDOW_SIZE * WINDOW_SIZE) / 2;
  localparam int unsigned HIST   = WINDOW_SIZE - 1;

  logic [CNT_W-1:0]               cnt_q [HIST];
  logic                           out_valid_q;
  bmwf_pkg::out_t                 out_q;

  logic                           head_emit;
  logic [CNT_W-1:0]               head_cnt;
  logic [bmwf_pkg::COL_OUT_W-1:0] head_col;
  logic [bmwf_pkg::ROW_W-1:0]     head_row;
  logic                           out_free;
  logic                           load_out;
  logic [SUM_W-1:0]               win_sum;

  assign {head_emit, head_cnt, head_col, head_row} = q_data_i;

  // A pixel without a result drains even while the output is held.
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = q_valid_i && (!head_emit || out_free);
  assign load_out = pop_o && head_emit;

  // Window count: the previous column counts plus the new one.
  always_comb begin
    win_sum = SUM_W'(head_cnt);
    for (int k = 0; k < HIST; k++) begin
      win_sum = win_sum + SUM_W'(cnt_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST; k++) begin
        cnt_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        for (int k = 0; k < HIST - 1; k++) begin
          cnt_q[k] <= cnt_q[k+1];
        end
        cnt_q[HIST-1] <= head_cnt;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload: majority vote and center coordinates.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.filtered_bit  <= (win_sum > SUM_W'(THRESH));
      out_q.center_column <= head_col;
      out_q.center_row    <= head_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> win_sum <= SUM_W'(WINDOW_SIZE * WINDOW_SIZE))
    else $error("window count exceeds the window area");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !load_out)
    else $error("held output transaction overwritten");
`endif

endmodule
